// ===== design/disc_collision_time_macros.svh =====
// Assertion helpers used by the checker file of disc_collision_time.
`ifndef DISC_COLLISION_TIME_MACROS_SVH
`define DISC_COLLISION_TIME_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, muted in reset.
`define DCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("disc_collision_time: check failed");

// Next-cycle implication, sampled at the rising clock edge, muted in reset.
`define DCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("disc_collision_time: check failed");

`endif

// ===== design/dct_pkg.sv =====
package dct_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned VEL_W  = 16;
  localparam int unsigned RAD_W  = 16;
  localparam int unsigned TIME_W = 24;
  localparam int unsigned S_W    = 34;
  localparam int unsigned Q_W    = 43;
  localparam int unsigned DISC_W = 70;
  localparam int unsigned ROOT_W = 35;
  localparam int unsigned ADDR_W = 3;

  localparam logic [RAD_W-1:0]  MARGIN_RESET = 16'd3;
  localparam logic [TIME_W-1:0] TIME_MAX     = 24'hFFFFFF;

  // Register index as decoded from paddr[2].
  localparam logic REG_MARGIN = 1'b0;

  typedef struct packed {
    logic                  pre;
    logic signed [Q_W-1:0] q;
    logic [S_W-1:0]        s;
  } dct_side_t;

  typedef struct packed {
    dct_side_t         side;
    logic [DISC_W-1:0] disc;
  } dct_front_t;

  typedef struct packed {
    dct_side_t         side;
    logic [ROOT_W-1:0] root;
    logic              rem_nz;
  } dct_root_t;

endpackage

// ===== design/dct_front.sv =====
module dct_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [23:0]       pos_x_a,
  input  logic signed [23:0]       pos_y_a,
  input  logic signed [15:0]       vel_x_a,
  input  logic signed [15:0]       vel_y_a,
  input  logic [15:0]              radius_a,
  input  logic signed [23:0]       pos_x_b,
  input  logic signed [23:0]       pos_y_b,
  input  logic signed [15:0]       vel_x_b,
  input  logic signed [15:0]       vel_y_b,
  input  logic [15:0]              radius_b,
  input  logic [15:0]              margin,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dct_pkg::dct_front_t      out_data
);
  import dct_pkg::*;

  localparam int unsigned NST = 7;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // Stage 1: differences and contact distance.
  logic signed [24:0] dx1, dy1;
  logic signed [16:0] va1, vb1;
  logic [17:0]        d1;
  // Stage 2: products.
  logic signed [33:0] aa2, bb2;
  logic signed [41:0] bdx2, ady2, dxa2, dyb2;
  logic [35:0]        dd2;
  // Stage 3: sums.
  logic [S_W-1:0]        s3;
  logic signed [Q_W-1:0] x3, q3;
  logic [35:0]           dd3;
  // Stage 4: magnitude of the cross term.
  logic [41:0]           ax4;
  logic [S_W-1:0]        s4;
  logic signed [Q_W-1:0] q4;
  logic [35:0]           dd4;
  logic                  pos4;
  logic signed [Q_W-1:0] negx3;
  // Stage 5: partial products.
  logic [52:0]           m0_5, m1_5;
  logic [41:0]           ll5, lh5, hh5;
  logic [S_W-1:0]        s5;
  logic signed [Q_W-1:0] q5;
  logic                  pos5;
  // Stage 6: assembled squares.
  logic [83:0]           dds6, xx6;
  logic [S_W-1:0]        s6;
  logic signed [Q_W-1:0] q6;
  logic                  pos6;
  // Stage 7: discriminant.
  logic [83:0]           diff6;

  assign en[NST-1]   = !v[NST-1] || out_ready;
  assign en[NST-2:0] = ~v[NST-2:0] | en[NST-1:1];
  assign in_ready    = en[0];
  assign out_valid   = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx1 <= {pos_x_a[23], pos_x_a} - {pos_x_b[23], pos_x_b};
      dy1 <= {pos_y_a[23], pos_y_a} - {pos_y_b[23], pos_y_b};
      va1 <= {vel_x_a[15], vel_x_a} - {vel_x_b[15], vel_x_b};
      vb1 <= {vel_y_a[15], vel_y_a} - {vel_y_b[15], vel_y_b};
      d1  <= {2'b00, radius_a} + {2'b00, radius_b} + {2'b00, margin};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      aa2  <= va1 * va1;
      bb2  <= vb1 * vb1;
      bdx2 <= vb1 * dx1;
      ady2 <= va1 * dy1;
      dxa2 <= dx1 * va1;
      dyb2 <= dy1 * vb1;
      dd2  <= d1 * d1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3  <= {1'b0, aa2[32:0]} + {1'b0, bb2[32:0]};
      x3  <= {bdx2[41], bdx2} - {ady2[41], ady2};
      q3  <= 43'sd0 - {dxa2[41], dxa2} - {dyb2[41], dyb2};
      dd3 <= dd2;
    end
  end

  assign negx3 = -x3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ax4  <= x3[Q_W-1] ? negx3[41:0] : x3[41:0];
      pos4 <= (q3 > 43'sd0) && (s3 != '0);
      s4   <= s3;
      q4   <= q3;
      dd4  <= dd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m0_5 <= dd4 * s4[16:0];
      m1_5 <= dd4 * s4[33:17];
      ll5  <= ax4[20:0] * ax4[20:0];
      lh5  <= ax4[20:0] * ax4[41:21];
      hh5  <= ax4[41:21] * ax4[41:21];
      s5   <= s4;
      q5   <= q4;
      pos5 <= pos4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      dds6 <= 84'(m0_5) + (84'(m1_5) << 17);
      xx6  <= 84'(ll5) + (84'(lh5) << 22) + (84'(hh5) << 42);
      s6   <= s5;
      q6   <= q5;
      pos6 <= pos5;
    end
  end

  assign diff6 = dds6 - xx6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      out_data.side.pre <= pos6 && (dds6 > xx6);
      out_data.side.q   <= q6;
      out_data.side.s   <= s6;
      out_data.disc     <= diff6[DISC_W-1:0];
    end
  end

endmodule

// ===== design/dct_sqrt.sv =====
module dct_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dct_pkg::dct_front_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dct_pkg::dct_root_t  out_data
);
  import dct_pkg::*;

  // One root bit per stage.
  localparam int unsigned NST = ROOT_W;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  logic [DISC_W-1:0] rad_r  [NST];
  logic [ROOT_W:0]   rem_r  [NST];
  logic [ROOT_W-1:0] root_r [NST];
  dct_side_t         side_r [NST];

  assign en[NST-1]   = !v[NST-1] || out_ready;
  assign en[NST-2:0] = ~v[NST-2:0] | en[NST-1:1];
  assign in_ready    = en[0];
  assign out_valid   = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_step
    logic [DISC_W-1:0] rad_i;
    logic [ROOT_W:0]   rem_i;
    logic [ROOT_W-1:0] root_i;
    dct_side_t         side_i;
    logic [ROOT_W+2:0] t;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_i  = in_data.disc;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_data.side;
    end else begin : g_rest
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign t     = {rem_i, rad_i[DISC_W-1:DISC_W-2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rad_r[k]  <= {rad_i[DISC_W-3:0], 2'b00};
        rem_r[k]  <= ge ? diff[ROOT_W:0] : t[ROOT_W:0];
        root_r[k] <= {root_i[ROOT_W-2:0], ge};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_data.side   = side_r[NST-1];
  assign out_data.root   = root_r[NST-1];
  assign out_data.rem_nz = |rem_r[NST-1];

endmodule

// ===== design/dct_div.sv =====
module dct_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dct_pkg::dct_root_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               will_hit,
  output logic [23:0]        hit_time
);
  import dct_pkg::*;

  // Ceiling, numerator, range check, one quotient bit per step, result.
  localparam int unsigned NSTEP = TIME_W;
  localparam int unsigned NST   = NSTEP + 4;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  logic [ROOT_W:0]       c0;
  dct_side_t             side0;
  logic signed [Q_W-1:0] qc0;
  logic                  hit1;
  logic [41:0]           num1;
  logic [S_W-1:0]        s1;
  logic [49:0]           numw1;
  logic                  hit2, sat2;
  logic [S_W-1:0]        s2, rem2;
  logic [TIME_W-1:0]     low2;

  logic [S_W-1:0]    rem_r [NSTEP];
  logic [TIME_W-1:0] low_r [NSTEP];
  logic [TIME_W-1:0] quo_r [NSTEP];
  logic [S_W-1:0]    s_r   [NSTEP];
  logic              hit_r [NSTEP];
  logic              sat_r [NSTEP];

  assign en[NST-1]   = !v[NST-1] || out_ready;
  assign en[NST-2:0] = ~v[NST-2:0] | en[NST-1:1];
  assign in_ready    = en[0];
  assign out_valid   = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c0    <= {1'b0, in_data.root} + {{ROOT_W{1'b0}}, in_data.rem_nz};
      side0 <= in_data.side;
    end
  end

  assign qc0 = side0.q - $signed({7'd0, c0});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hit1 <= side0.pre && !qc0[Q_W-1];
      num1 <= qc0[41:0];
      s1   <= side0.s;
    end
  end

  assign numw1 = {num1, 8'd0};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sat2 <= {8'd0, numw1[49:24]} >= s1;
      rem2 <= {8'd0, numw1[49:24]};
      low2 <= numw1[23:0];
      hit2 <= hit1;
      s2   <= s1;
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic [S_W-1:0]    rem_i;
    logic [TIME_W-1:0] low_i;
    logic [TIME_W-1:0] quo_i;
    logic [S_W-1:0]    s_i;
    logic              hit_i;
    logic              sat_i;
    logic [S_W:0]      t;
    logic [S_W:0]      diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_i = rem2;
      assign low_i = low2;
      assign quo_i = '0;
      assign s_i   = s2;
      assign hit_i = hit2;
      assign sat_i = sat2;
    end else begin : g_rest
      assign rem_i = rem_r[j-1];
      assign low_i = low_r[j-1];
      assign quo_i = quo_r[j-1];
      assign s_i   = s_r[j-1];
      assign hit_i = hit_r[j-1];
      assign sat_i = sat_r[j-1];
    end

    assign t    = {rem_i, low_i[TIME_W-1]};
    assign ge   = t >= {1'b0, s_i};
    assign diff = t - {1'b0, s_i};

    always_ff @(posedge clk) begin
      if (en[j+3]) begin
        rem_r[j] <= ge ? diff[S_W-1:0] : t[S_W-1:0];
        low_r[j] <= {low_i[TIME_W-2:0], 1'b0};
        quo_r[j] <= {quo_i[TIME_W-2:0], ge};
        s_r[j]   <= s_i;
        hit_r[j] <= hit_i;
        sat_r[j] <= sat_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      will_hit <= hit_r[NSTEP-1];
      if (!hit_r[NSTEP-1]) begin
        hit_time <= '0;
      end else if (sat_r[NSTEP-1]) begin
        hit_time <= TIME_MAX;
      end else begin
        hit_time <= quo_r[NSTEP-1];
      end
    end
  end

endmodule

// ===== design/disc_collision_time.sv =====
// Contact-time predictor for a pair of moving discs.
// Input channel: in_valid / in_stall carry one pair (positions Q16.8, velocities
// Q8.8, radii Q8.8) per transaction; a transaction completes on a rising edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry will_hit and hit_time (Q16.8,
// saturated, zero on a miss), one result transaction per input transaction.
// 7 stages form the discriminant, 35 stages extract its square root one bit
// each, and 28 stages form the numerator and produce the 24 quotient bits one
// per stage. Throughput is one pair per cycle while out_stall is low; every
// stage holds its own valid bit. When out_stall is high the stages behind the
// output keep advancing into empty slots, so in_stall rises only once all 70
// stages hold a transaction. A stalled result holds steady on the output ports.
// Reset (synchronous, rst high) clears all valid bits and sets contact_margin
// to 3; no clearing pass is needed. The margin register sits at address 0 of
// the APB port and should be written only while the pipeline is empty.
module disc_collision_time (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [dct_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [23:0]       pos_x_a,
  input  logic signed [23:0]       pos_y_a,
  input  logic signed [15:0]       vel_x_a,
  input  logic signed [15:0]       vel_y_a,
  input  logic [15:0]              radius_a,
  input  logic signed [23:0]       pos_x_b,
  input  logic signed [23:0]       pos_y_b,
  input  logic signed [15:0]       vel_x_b,
  input  logic signed [15:0]       vel_y_b,
  input  logic [15:0]              radius_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     will_hit,
  output logic [23:0]              hit_time
);
  import dct_pkg::*;

  logic [RAD_W-1:0] contact_margin;
  logic             front_in_ready;
  logic             front_valid, sqrt_in_ready;
  dct_front_t       front_data;
  logic             root_valid, div_in_ready;
  dct_root_t        root_data;

  // The register port never waits.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_margin <= MARGIN_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MARGIN)) begin
      contact_margin <= pwdata[RAD_W-1:0];
    end
  end

  // Reads of unused addresses return zero.
  assign prdata = (paddr[2] == REG_MARGIN) ? {16'd0, contact_margin} : 32'd0;

  assign in_stall = !front_in_ready;

  // Discriminant of the contact equation.
  dct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (front_in_ready),
    .pos_x_a   (pos_x_a),
    .pos_y_a   (pos_y_a),
    .vel_x_a   (vel_x_a),
    .vel_y_a   (vel_y_a),
    .radius_a  (radius_a),
    .pos_x_b   (pos_x_b),
    .pos_y_b   (pos_y_b),
    .vel_x_b   (vel_x_b),
    .vel_y_b   (vel_y_b),
    .radius_b  (radius_b),
    .margin    (contact_margin),
    .out_valid (front_valid),
    .out_ready (sqrt_in_ready),
    .out_data  (front_data)
  );

  // Integer square root, one result bit per stage.
  dct_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (sqrt_in_ready),
    .in_data   (front_data),
    .out_valid (root_valid),
    .out_ready (div_in_ready),
    .out_data  (root_data)
  );

  // Hit decision and restoring division by the squared relative speed.
  dct_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (root_valid),
    .in_ready  (div_in_ready),
    .in_data   (root_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .will_hit  (will_hit),
    .hit_time  (hit_time)
  );

endmodule

// ===== design/dct_checker.sv =====
`include "disc_collision_time_macros.svh"

module dct_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic                     pready,
  input logic [dct_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]              pwdata,
  input logic [31:0]              prdata,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     will_hit,
  input logic [23:0]              hit_time
);
  import dct_pkg::*;

  logic        margin_sel;
  logic        margin_wr;
  logic [31:0] margin_word;

  assign margin_sel  = (paddr[2] == REG_MARGIN);
  assign margin_wr   = psel && penable && pwrite && pready && margin_sel;
  assign margin_word = {16'd0, pwdata[15:0]};

  // A miss always reports a zero time.
  `DCT_ASSERT_NOW(a_miss_zero, out_valid && !will_hit, hit_time == '0)

  // The input side only backs up when a finished result is being held.
  `DCT_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // A held result stays on the port.
  `DCT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable({will_hit, hit_time}))

  // A margin write reads back on the next cycle.
  `DCT_ASSERT_NEXT(a_readback, margin_wr, !margin_sel || (prdata == $past(margin_word)))

endmodule

bind disc_collision_time dct_checker u_dct_checker (.*);

// ===== tb/tb_disc_collision_time.sv =====
`timescale 1ns / 1ps

module tb_disc_collision_time;
  import dct_pkg::*;

  // One pair of moving discs as carried by a single input transaction.
  typedef struct {
    logic signed [23:0] pxa, pya, pxb, pyb;
    logic signed [15:0] vxa, vya, vxb, vyb;
    logic [15:0]        ra, rb;
  } disc_pair_t;

  // Expected contact result of one pair.
  typedef struct {
    bit          hit;
    logic [23:0] t;
  } contact_t;

  // A row of the directed table. Where the outcome is obvious from the
  // geometry it is typed in; otherwise the predictor decides.
  typedef struct {
    disc_pair_t p;
    bit         typed;
    contact_t   res;
  } pair_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [23:0] pos_x_a = '0, pos_y_a = '0, pos_x_b = '0, pos_y_b = '0;
  logic signed [15:0] vel_x_a = '0, vel_y_a = '0, vel_x_b = '0, vel_y_b = '0;
  logic [15:0]        radius_a = '0, radius_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               will_hit;
  logic [23:0]        hit_time;

  // The testbench's own copy of the contact margin register.
  logic [15:0] margin_shadow = MARGIN_RESET;
  contact_t    pending_contacts[$];
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_hits = 0;
  int unsigned n_margins = 0;

  disc_collision_time u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x_a(pos_x_a), .pos_y_a(pos_y_a), .vel_x_a(vel_x_a), .vel_y_a(vel_y_a),
    .radius_a(radius_a),
    .pos_x_b(pos_x_b), .pos_y_b(pos_y_b), .vel_x_b(vel_x_b), .vel_y_b(vel_y_b),
    .radius_b(radius_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .will_hit(will_hit), .hit_time(hit_time)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Smallest integer whose square is not below v; v stays under 2^72.
  function automatic logic [127:0] root_up(logic [127:0] v);
    logic [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'd1 << 36;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    if (lo * lo != v) lo = lo + 1;
    return lo;
  endfunction

  // Earliest contact time of two discs. All work is exact integer math:
  // differences in Q.8, squared speed and the projections in Q.16, and the
  // discriminant in Q.32, held in 128 bits so nothing can wrap.
  function automatic contact_t contact_time(disc_pair_t p, logic [15:0] margin);
    longint       dx, dy, va, vb, x, q, d, s, ax;
    logic [127:0] dds, xx, c, num;
    contact_t     r;
    dx = longint'(p.pxa) - longint'(p.pxb);
    dy = longint'(p.pya) - longint'(p.pyb);
    va = longint'(p.vxa) - longint'(p.vxb);
    vb = longint'(p.vya) - longint'(p.vyb);
    d  = longint'(p.ra) + longint'(p.rb) + longint'(margin);
    s  = va * va + vb * vb;
    x  = vb * dx - va * dy;
    q  = -(dx * va + dy * vb);
    ax = (x < 0) ? -x : x;
    dds = 128'(d * d) * 128'(s);
    xx  = 128'(ax) * 128'(ax);
    r.hit = 1'b0;
    r.t   = '0;
    // A pair that is not closing in, or whose path misses, never touches.
    if (dds > xx && s != 0 && q > 0) begin
      c = root_up(dds - xx);
      if (128'(q) >= c) begin
        r.hit = 1'b1;
        num = ((128'(q) - c) << 8) / 128'(s);
        r.t = (num > 128'(TIME_MAX)) ? TIME_MAX : num[23:0];
      end
    end
    return r;
  endfunction

  // Fully random pair: every bit of every field can take either value.
  function automatic disc_pair_t random_pair();
    disc_pair_t p;
    p.pxa = 24'($urandom); p.pya = 24'($urandom);
    p.pxb = 24'($urandom); p.pyb = 24'($urandom);
    p.vxa = 16'($urandom); p.vya = 16'($urandom);
    p.vxb = 16'($urandom); p.vyb = 16'($urandom);
    p.ra  = 16'($urandom); p.rb  = 16'($urandom);
    return p;
  endfunction

  function automatic int clamp(int v, int lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  // A pair on a near-collision course: the discs sit a random distance
  // apart and their relative velocity points back along the gap, with a
  // little sideways error so that grazing misses show up too.
  function automatic disc_pair_t closing_pair();
    disc_pair_t p;
    int ox, oy, rvx, rvy, vax, vay, scale, sh;
    scale = $urandom_range(20, 4);
    sh    = $urandom_range(scale - 1, 0);
    ox  = $urandom_range(2 ** scale, 0) - 2 ** (scale - 1);
    oy  = $urandom_range(2 ** scale, 0) - 2 ** (scale - 1);
    rvx = clamp(-(ox >>> sh) + $urandom_range(64, 0) - 32, 16383);
    rvy = clamp(-(oy >>> sh) + $urandom_range(64, 0) - 32, 16383);
    vax = $urandom_range(32766, 0) - 16383;
    vay = $urandom_range(32766, 0) - 16383;
    p.pxa = 24'($urandom_range(4194304, 0) - 2097152);
    p.pya = 24'($urandom_range(4194304, 0) - 2097152);
    p.pxb = 24'(int'(p.pxa) - ox);
    p.pyb = 24'(int'(p.pya) - oy);
    p.vxa = 16'(vax);
    p.vya = 16'(vay);
    p.vxb = 16'(vax - rvx);
    p.vyb = 16'(vay - rvy);
    p.ra  = 16'($urandom_range(2 ** $urandom_range(16, 4) - 1, 0));
    p.rb  = 16'($urandom_range(2 ** $urandom_range(16, 4) - 1, 0));
    return p;
  endfunction

  // Sender. Fields change only at a rising edge, and a pair is held steady
  // until the edge at which in_valid is high and in_stall is low. The
  // expectation is queued at that edge, long before the result can appear.
  task automatic send_pair(disc_pair_t p, bit typed, contact_t res);
    in_valid <= 1'b1;
    pos_x_a <= p.pxa; pos_y_a <= p.pya; vel_x_a <= p.vxa; vel_y_a <= p.vya;
    radius_a <= p.ra;
    pos_x_b <= p.pxb; pos_y_b <= p.pyb; vel_x_b <= p.vxb; vel_y_b <= p.vyb;
    radius_b <= p.rb;
    do @(posedge clk); while (in_stall);
    pending_contacts.push_back(typed ? res : contact_time(p, margin_shadow));
  endtask

  // Bursts of back-to-back transactions, most of them separated by random idle gaps.
  int unsigned burst_left = 0;
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Pause the sender until every outstanding result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_contacts.size() != 0) @(posedge clk);
  endtask

  // APB write of the margin, followed by a read back of the same register.
  task automatic set_margin(logic [15:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_MARGIN, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    margin_shadow = value;
    n_margins++;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== value) begin
      $error("contact_margin: expected %0d, actual %0d", value, prdata[15:0]);
      n_errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  // The receiver stalls on a pattern of its own that is chosen anew at regular
  // intervals: no stall at all, light random stall, heavy random stall, or long
  // solid stretches.
  int unsigned stall_cycle = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 300 == 0) stall_mode <= $urandom_range(3, 0);
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(9, 0) < 2);
      end
      2: begin
        out_stall <= ($urandom_range(9, 0) < 7);
      end
      default: begin
        out_stall <= ((stall_cycle / 23) % 3 == 0);
      end
    endcase
  end

  // Result checker: every result transaction is matched against the oldest
  // outstanding expectation, field by field.
  always @(posedge clk) begin
    contact_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_contacts.size() == 0) begin
        $error("will_hit/hit_time: result with nothing outstanding");
        n_errors++;
      end else begin
        want = pending_contacts.pop_front();
        n_results++;
        if (will_hit) n_hits++;
        if (will_hit !== want.hit) begin
          $error("will_hit: expected %0d, actual %0d", want.hit, will_hit);
          n_errors++;
        end
        if (hit_time !== want.t) begin
          $error("hit_time: expected %0d, actual %0d", want.t, hit_time);
          n_errors++;
        end
      end
    end
  end

  // Directed table, run with the margin at its reset value of 3.
  localparam int N_ROWS = 9;
  pair_row_t rows[N_ROWS];

  initial begin
    contact_t   none;
    contact_t   sat;
    disc_pair_t z;
    none.hit = 1'b0; none.t = '0;
    sat.hit = 1'b1;  sat.t = TIME_MAX;
    z = '{default: '0};
    foreach (rows[i]) rows[i] = '{p: z, typed: 1'b0, res: none};

    // Both discs at rest on top of each other: no relative motion, no hit.
    rows[0].typed = 1'b1;
    // Opposite corners of the plane with equal top velocities: never closer.
    rows[1].p.pxa = 24'sh7FFFFF; rows[1].p.pya = 24'sh7FFFFF;
    rows[1].p.pxb = 24'sh800000; rows[1].p.pyb = 24'sh800000;
    rows[1].p.vxa = 16'sh7FFF; rows[1].p.vxb = 16'sh7FFF;
    rows[1].p.vya = 16'sh8000; rows[1].p.vyb = 16'sh8000;
    rows[1].typed = 1'b1;
    // Overlapping centers while moving: the numerator is not positive.
    rows[2].p.pxa = 24'sd5000; rows[2].p.pxb = 24'sd5000;
    rows[2].p.vxa = 16'sd300; rows[2].p.ra = 16'hFFFF; rows[2].p.rb = 16'hFFFF;
    rows[2].typed = 1'b1;
    // Head-on approach along x at one unit per step from ten units away.
    rows[3].p.pxb = 24'sd2560; rows[3].p.vxa = 16'sd256;
    // The same pair moving apart instead.
    rows[4].p.pxb = 24'sd2560; rows[4].p.vxa = -16'sd256;
    rows[4].typed = 1'b1;
    // Full width apart at the slowest speed: the time saturates.
    rows[5].p.pxa = 24'sh800000; rows[5].p.pxb = 24'sh7FFFFF;
    rows[5].p.vxa = 16'sd1;
    rows[5].res = sat; rows[5].typed = 1'b1;
    // Fastest opposing velocities with the largest radii.
    rows[6].p.pxa = 24'sh800000; rows[6].p.pya = 24'sh800000;
    rows[6].p.pxb = 24'sh7FFFFF; rows[6].p.pyb = 24'sh7FFFFF;
    rows[6].p.vxa = 16'sh7FFF; rows[6].p.vya = 16'sh7FFF;
    rows[6].p.vxb = 16'sh8000; rows[6].p.vyb = 16'sh8000;
    rows[6].p.ra = 16'hFFFF; rows[6].p.rb = 16'hFFFF;
    // Offset sideways by just the contact distance, but moving apart along y.
    rows[7].p.pxb = 24'sd259; rows[7].p.pyb = 24'sd4000;
    rows[7].p.vya = -16'sd128; rows[7].p.ra = 16'd128; rows[7].p.rb = 16'd128;
    // A diagonal approach with both discs moving.
    rows[8].p.pxa = -24'sd9000; rows[8].p.pya = -24'sd7000;
    rows[8].p.vxa = 16'sd700; rows[8].p.vya = 16'sd500;
    rows[8].p.vxb = -16'sd100; rows[8].p.vyb = -16'sd80;
    rows[8].p.ra = 16'd900; rows[8].p.rb = 16'd400;
  end

  initial begin
    logic [15:0] margins[5];
    contact_t    none;
    none.hit = 1'b0; none.t = '0;
    margins = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), MARGIN_RESET};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      pace();
      send_pair(rows[i].p, rows[i].typed, rows[i].res);
    end
    drain();

    // Random traffic in phases, each under a different margin. Most pairs
    // are on a collision course; the rest are arbitrary and almost always
    // miss.
    foreach (margins[m]) begin
      set_margin(margins[m]);
      repeat (400) begin
        pace();
        if ($urandom_range(9, 0) < 7) send_pair(closing_pair(), 1'b0, none);
        else send_pair(random_pair(), 1'b0, none);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Checked %0d contact results (%0d hits) across %0d margin settings.",
             n_results, n_hits, n_margins + 1);
    if (n_errors == 0 && pending_contacts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Run did not complete in time.");
    $display("TEST FAILED");
    $finish;
  end

endmodule
